// ----- rtl/cap_pkg.sv -----
// Shared types, constants and arctangent table for the camera pan/tilt aim unit.
// No dependencies; every other file imports this package.
package cap_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;

  // Item kinds
  localparam logic [2:0] KIND_ROW0 = 3'd0;
  localparam logic [2:0] KIND_ROW1 = 3'd1;
  localparam logic [2:0] KIND_ROW2 = 3'd2;
  localparam logic [2:0] KIND_POS  = 3'd3;
  localparam logic [2:0] KIND_AIM  = 3'd4;

  localparam int MAG_W     = 51;  // |c| < 3 * 2^49
  localparam int SCALE_W   = 30;  // normalized magnitude width
  localparam int SQRT_BITS = 31;  // floor sqrt of a 61-bit value
  localparam int SQRT_W    = 62;
  localparam int CW        = 34;  // CORDIC datapath and angle accumulator

  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam logic [18:0] NV_SCALE = 19'd499999;

  localparam logic [31:0] ATAN_Q30 [0:31] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] last_yaw;
    logic               first_update;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               near_vertical;
  } out_beat_t;

  // Per-beat control that rides along the pipeline
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     zero;
    logic                     nv;
    logic signed [15:0]       prev;
    logic signed [SCALE_W:0]  sx;
    logic signed [SCALE_W:0]  sy;
    logic signed [SCALE_W:0]  sz;
  } side_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]      orv;
    logic [2:0]            neg;
  } norm_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] acc;
  } lane_t;

endpackage

// ----- rtl/camera_aim_pan_tilt_unit.sv -----
// Top level of the camera pan/tilt aim unit: pose registers and the aim pipeline.
// Depends on cap_pkg, cap_norm_cell, cap_sqrt_cell and cap_cordic_cell.
//
// Usage
//   Input channel: a beat is taken on each rising edge with start high and busy
//   low. busy is never raised: the unit takes one beat every cycle.
//   Beats of kind 0..2 load one row of the rotation matrix (entries saturate to
//   Q1.16), kind 3 loads the camera position; they give no result and act at
//   once, so an aim beat that follows next cycle already sees the new pose.
//   Kind 4 is an aim request; kinds 5..7 are dropped.
//   Result channel: each aim beat gives one result on res, marked by done for a
//   single cycle, in input order. The receiver cannot stall, so there is no
//   back pressure anywhere in the pipeline.
//   Pipeline order: 3-term matrix product, 6-step normalizer, near-vertical
//   test, 31-step square root, the CORDIC cell chain and the yaw continuity
//   selection. Throughput: one aim beat per cycle.
//   Reset: synchronous; the matrix returns to identity, the camera position to
//   zero and all beats in flight are dropped.
module camera_aim_pan_tilt_unit #(
  parameter int ANGLE_FRAC_BITS = cap_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = cap_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cap_pkg::in_beat_t item,
  output logic              done,
  output cap_pkg::out_beat_t res
);
  import cap_pkg::*;

  // Angle scaling constants, all at elaboration
  localparam int     SH       = 30 - ANGLE_FRAC_BITS;
  localparam longint PI_Q     = (Q30_PI + (longint'(1) << (SH - 1))) >>> SH;
  localparam longint HALF_Q   = (Q30_HALF_PI + (longint'(1) << (SH - 1))) >>> SH;
  localparam longint TWO_PI_Q = 2 * PI_Q;
  localparam longint NOFF     = 32768 / TWO_PI_Q + 1;
  localparam longint OFF      = TWO_PI_Q * NOFF;
  localparam longint RECIP    = (longint'(1) << 32) / TWO_PI_Q;
  localparam logic signed [CW:0] RND = (CW + 1)'(longint'(1) << (SH - 1));
  localparam int PW = 51;   // matrix product width
  localparam int CSW = 53;  // camera-frame sum width
  localparam int UW = 18;   // offset prev yaw for the modulo
  localparam int QW = 8;    // quotient of that modulo
  localparam int DW = 18;   // yaw difference width

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- pose registers ----------------
  logic signed [17:0] rot [3][3];
  logic signed [31:0] cam [3];
  logic signed [31:0] vin [3];

  assign vin[0] = item.vec_x;
  assign vin[1] = item.vec_y;
  assign vin[2] = item.vec_z;

  function automatic logic signed [17:0] sat18(logic signed [31:0] v);
    if (v > 32'sd131071) begin
      return 18'sd131071;
    end else if (v < -32'sd131072) begin
      return -18'sd131072;
    end
    return v[17:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          rot[j][i] <= (i == j) ? 18'sd65536 : 18'sd0;
        end
        cam[j] <= '0;
      end
    end else if (accept) begin
      unique case (item.kind)
        KIND_ROW0, KIND_ROW1, KIND_ROW2: begin
          for (int i = 0; i < 3; i++) begin
            rot[item.kind[1:0]][i] <= sat18(vin[i]);
          end
        end
        KIND_POS: begin
          for (int i = 0; i < 3; i++) begin
            cam[i] <= vin[i];
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- p0: offset and pose snapshot ----------------
  logic signed [32:0] p0_d [3];
  logic signed [17:0] p0_r [3][3];
  side_t              p0_side, p0_side_next;

  always_comb begin
    p0_side_next       = '0;
    p0_side_next.valid = accept && (item.kind == KIND_AIM);
    p0_side_next.first = item.first_update;
    p0_side_next.prev  = item.last_yaw;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p0_d[i] <= $signed({vin[i][31], vin[i]}) - $signed({cam[i][31], cam[i]});
    end
    p0_r <= rot;
    if (rst) begin
      p0_side <= '0;
    end else begin
      p0_side <= p0_side_next;
    end
  end

  // ---------------- p1: nine products, p2: column sums ----------------
  // c_i = sum_j R[j][i] * d_j, i.e. R transposed times the offset
  logic signed [PW-1:0]  p1_prod [3][3];
  logic signed [CSW-1:0] p2_c [3];
  side_t                 p1_side, p2_side;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        p1_prod[j][i] <= p0_r[j][i] * p0_d[j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      p2_c[i] <= p1_prod[0][i] + p1_prod[1][i] + p1_prod[2][i];
    end
    if (rst) begin
      p1_side <= '0;
      p2_side <= '0;
    end else begin
      p1_side <= p0_side;
      p2_side <= p1_side;
    end
  end

  // ---------------- p3: magnitudes and zero test ----------------
  norm_t p3_norm, p3_norm_next;
  side_t p3_side, p3_side_next;

  always_comb begin
    logic signed [CSW-1:0] a;
    p3_norm_next = '0;
    for (int i = 0; i < 3; i++) begin
      a = p2_c[i][CSW-1] ? -p2_c[i] : p2_c[i];
      p3_norm_next.mag[i] = a[MAG_W-1:0];
      p3_norm_next.neg[i] = p2_c[i][CSW-1];
    end
    p3_norm_next.orv = p3_norm_next.mag[0] | p3_norm_next.mag[1] | p3_norm_next.mag[2];
    p3_side_next      = p2_side;
    p3_side_next.zero = (p3_norm_next.orv == '0);
  end

  always_ff @(posedge clk) begin
    p3_norm <= p3_norm_next;
    if (rst) begin
      p3_side <= '0;
    end else begin
      p3_side <= p3_side_next;
    end
  end

  // ---------------- normalizer chain: 32,16,8,4,2,1 ----------------
  // Leaves the largest magnitude with its top bit at MAG_W-1; the top SCALE_W
  // bits then match the common power-of-two scaling with truncation.
  norm_t nrm [0:6];
  side_t nsd [0:6];

  assign nrm[0] = p3_norm;
  assign nsd[0] = p3_side;

  for (genvar k = 0; k < 6; k++) begin : g_norm
    cap_norm_cell #(.SHIFT(32 >> k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .nin  (nrm[k]),
      .sin  (nsd[k]),
      .nout (nrm[k+1]),
      .sout (nsd[k+1])
    );
  end

  // ---------------- n1..n4: squares and near-vertical test ----------------
  logic [SCALE_W-1:0]     m30 [3];
  logic [SCALE_W-10:0]    a21 [3];
  logic [2*SCALE_W-19:0]  n1_sa [3];
  logic [2*SCALE_W-1:0]   n1_sm [2];
  side_t                  n1_side, n1_side_next;
  logic [2*SCALE_W-18:0]  n2_xy2;
  logic [2*SCALE_W-19:0]  n2_z2;
  logic [2*SCALE_W:0]     n2_r2;
  logic [61:0]            n3_nvp;
  logic [2*SCALE_W-19:0]  n3_z2;
  logic [2*SCALE_W:0]     n3_r2;
  logic [2*SCALE_W:0]     n4_r2;
  side_t                  n2_side, n3_side, n4_side, n4_side_next;

  always_comb begin
    n1_side_next = nsd[6];
    for (int i = 0; i < 3; i++) begin
      m30[i] = nrm[6].mag[i][MAG_W-1 -: SCALE_W];
      a21[i] = m30[i][SCALE_W-1:9];
    end
    n1_side_next.sx = nrm[6].neg[0] ? -$signed({1'b0, m30[0]}) : $signed({1'b0, m30[0]});
    n1_side_next.sy = nrm[6].neg[1] ? -$signed({1'b0, m30[1]}) : $signed({1'b0, m30[1]});
    n1_side_next.sz = nrm[6].neg[2] ? -$signed({1'b0, m30[2]}) : $signed({1'b0, m30[2]});
    n4_side_next    = n3_side;
    n4_side_next.nv = (n3_nvp < {20'd0, n3_z2});
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n1_sa[i] <= a21[i] * a21[i];
    end
    for (int i = 0; i < 2; i++) begin
      n1_sm[i] <= m30[i] * m30[i];
    end
    n2_xy2  <= n1_sa[0] + n1_sa[1];
    n2_z2   <= n1_sa[2];
    n2_r2   <= n1_sm[0] + n1_sm[1];
    n3_nvp  <= n2_xy2 * NV_SCALE;
    n3_z2   <= n2_z2;
    n3_r2   <= n2_r2;
    n4_r2   <= n3_r2;
    if (rst) begin
      n1_side <= '0;
      n2_side <= '0;
      n3_side <= '0;
      n4_side <= '0;
    end else begin
      n1_side <= n1_side_next;
      n2_side <= n1_side;
      n3_side <= n2_side;
      n4_side <= n4_side_next;
    end
  end

  // ---------------- square root chain: one result bit per cell ----------------
  logic [SQRT_W-1:0] sq_v [0:SQRT_BITS];
  logic [SQRT_W-1:0] sq_r [0:SQRT_BITS];
  side_t             sq_side [0:SQRT_BITS];

  assign sq_v[0]    = SQRT_W'(n4_r2);
  assign sq_r[0]    = '0;
  assign sq_side[0] = n4_side;

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    cap_sqrt_cell #(.BIT(SQRT_BITS - 1 - k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .vin  (sq_v[k]),
      .rin  (sq_r[k]),
      .sin  (sq_side[k]),
      .vout (sq_v[k+1]),
      .rout (sq_r[k+1]),
      .sout (sq_side[k+1])
    );
  end

  // ---------------- CORDIC setup and chain ----------------
  // Left half-plane vectors are turned by pi before the iterations.
  function automatic lane_t pre_rot(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    lane_t l;
    if (x[CW-1]) begin
      l.x   = -x;
      l.y   = -y;
      l.acc = y[CW-1] ? -CW'(Q30_PI) : CW'(Q30_PI);
    end else begin
      l.x   = x;
      l.y   = y;
      l.acc = '0;
    end
    return l;
  endfunction

  lane_t yl [0:CORDIC_STAGES];
  lane_t pl [0:CORDIC_STAGES];
  side_t cs_side [0:CORDIC_STAGES];
  logic [SQRT_BITS-1:0] root;

  assign root = sq_r[SQRT_BITS][SQRT_BITS-1:0];

  always_ff @(posedge clk) begin
    yl[0] <= pre_rot(CW'(sq_side[SQRT_BITS].sx), CW'(sq_side[SQRT_BITS].sy));
    pl[0] <= pre_rot(CW'(sq_side[SQRT_BITS].sz), $signed(CW'(root)));
    if (rst) begin
      cs_side[0] <= '0;
    end else begin
      cs_side[0] <= sq_side[SQRT_BITS];
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    cap_cordic_cell #(.IDX(k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .yin  (yl[k]),
      .pin  (pl[k]),
      .sin  (cs_side[k]),
      .yout (yl[k+1]),
      .pout (pl[k+1]),
      .sout (cs_side[k+1])
    );
  end

  // ---------------- a1..a4: angles and yaw continuity ----------------
  // Q2.30 to output precision, round half up, clamp to +/-pi
  function automatic logic signed [15:0] to_ang(logic signed [CW-1:0] a);
    logic signed [CW:0] t;
    t = $signed({a[CW-1], a}) + RND;
    t = t >>> SH;
    if (t > PI_Q) begin
      return 16'(PI_Q);
    end else if (t < -PI_Q) begin
      return 16'(-PI_Q);
    end
    return t[15:0];
  endfunction

  // single fold for values within +/-2pi
  function automatic logic signed [DW-1:0] fold(logic signed [DW-1:0] x);
    if (x > PI_Q) begin
      return x - DW'(TWO_PI_Q);
    end else if (x < -PI_Q) begin
      return x + DW'(TWO_PI_Q);
    end
    return x;
  endfunction

  logic signed [15:0] a1_yaw, a1_pitch, a2_yaw, a2_pitch, a3_yaw, a3_pitch, a4_yaw, a4_pitch;
  logic [UW-1:0]      a1_u, a2_u;
  logic [QW-1:0]      a2_q;
  logic [63:0]        qmul;
  logic signed [15:0] a3_pw, a3_yaw2, a4_yaw2;
  logic               a4_pick;
  side_t              a1_side, a2_side, a3_side, a4_side;
  logic [UW:0]        tm;
  logic [UW:0]        tmod;
  logic signed [15:0] pw_next;
  logic signed [DW-1:0] d1, d2, d1a, d2a;

  assign qmul = 64'(a1_u) * 64'(RECIP);

  always_comb begin
    // (prev + pi) mod 2pi by reciprocal, one correction step
    tm   = (UW + 1)'(a2_u) - (UW + 1)'(a2_q * TWO_PI_Q);
    tmod = (tm >= (UW + 1)'(TWO_PI_Q)) ? tm - (UW + 1)'(TWO_PI_Q) : tm;
    if (a2_side.prev <= PI_Q && a2_side.prev >= -PI_Q) begin
      pw_next = a2_side.prev;
    end else begin
      pw_next = 16'($signed({1'b0, tmod}) - PI_Q);
    end
    d1  = fold(DW'(a3_yaw) - DW'(a3_pw));
    d2  = fold(DW'(a3_yaw2) - DW'(a3_pw));
    d1a = d1[DW-1] ? -d1 : d1;
    d2a = d2[DW-1] ? -d2 : d2;
  end

  always_ff @(posedge clk) begin
    a1_yaw   <= to_ang(yl[CORDIC_STAGES].acc);
    a1_pitch <= to_ang(pl[CORDIC_STAGES].acc);
    a1_u     <= UW'(longint'(cs_side[CORDIC_STAGES].prev) + PI_Q + OFF);
    a2_yaw   <= a1_yaw;
    a2_pitch <= a1_pitch;
    a2_u     <= a1_u;
    a2_q     <= qmul[32 +: QW];
    a3_yaw   <= a2_yaw;
    a3_pitch <= a2_pitch;
    a3_pw    <= pw_next;
    a3_yaw2  <= (a2_yaw >= 0) ? a2_yaw - 16'(PI_Q) : a2_yaw + 16'(PI_Q);
    a4_yaw   <= a3_yaw;
    a4_pitch <= a3_pitch;
    a4_yaw2  <= a3_yaw2;
    a4_pick  <= (d1a <= d2a);  // base solution wins a tie
    if (rst) begin
      a1_side <= '0;
      a2_side <= '0;
      a3_side <= '0;
      a4_side <= '0;
    end else begin
      a1_side <= cs_side[CORDIC_STAGES];
      a2_side <= a1_side;
      a3_side <= a2_side;
      a4_side <= a3_side;
    end
  end

  // ---------------- result register ----------------
  out_beat_t res_next;

  always_comb begin
    priority if (a4_side.zero) begin
      res_next.pitch         = 16'(HALF_Q);
      res_next.yaw           = '0;
      res_next.near_vertical = 1'b0;
    end else if (a4_side.nv) begin
      res_next.pitch         = '0;
      res_next.yaw           = a4_side.first ? 16'sd0 : a4_side.prev;
      res_next.near_vertical = 1'b1;
    end else if (a4_side.first || a4_pick) begin
      res_next.pitch         = a4_pitch;
      res_next.yaw           = a4_yaw;
      res_next.near_vertical = 1'b0;
    end else begin
      res_next.pitch         = -a4_pitch;
      res_next.yaw           = a4_yaw2;
      res_next.near_vertical = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a4_side.valid;
    end
  end

endmodule

// ----- rtl/cap_norm_cell.sv -----
// One step of the pipelined normalizer: shift left by SHIFT when the top bits are clear.
// Depends on cap_pkg.
module cap_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cap_pkg::norm_t nin,
  input  cap_pkg::side_t sin,
  output cap_pkg::norm_t nout,
  output cap_pkg::side_t sout
);
  import cap_pkg::*;

  norm_t nxt;

  always_comb begin
    nxt = nin;
    if (nin.orv[MAG_W-1 -: SHIFT] == '0) begin
      for (int i = 0; i < 3; i++) begin
        nxt.mag[i] = nin.mag[i] << SHIFT;
      end
      nxt.orv = nin.orv << SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    nout <= nxt;
    if (rst) begin
      sout <= '0;
    end else begin
      sout <= sin;
    end
  end

endmodule

// ----- rtl/cap_sqrt_cell.sv -----
// One result bit of the pipelined floor square root (restoring, digit BIT).
// Depends on cap_pkg.
module cap_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [cap_pkg::SQRT_W-1:0] vin,
  input  logic [cap_pkg::SQRT_W-1:0] rin,
  input  cap_pkg::side_t             sin,
  output logic [cap_pkg::SQRT_W-1:0] vout,
  output logic [cap_pkg::SQRT_W-1:0] rout,
  output cap_pkg::side_t             sout
);
  import cap_pkg::*;

  localparam logic [SQRT_W-1:0] ONE = SQRT_W'(1) << (2 * BIT);

  logic [SQRT_W-1:0] trial;

  assign trial = rin + ONE;

  always_ff @(posedge clk) begin
    if (vin >= trial) begin
      vout <= vin - trial;
      rout <= (rin >> 1) + ONE;
    end else begin
      vout <= vin;
      rout <= rin >> 1;
    end
    if (rst) begin
      sout <= '0;
    end else begin
      sout <= sin;
    end
  end

endmodule

// ----- rtl/cap_cordic_cell.sv -----
// One CORDIC vectoring iteration for the yaw and pitch lanes side by side.
// Depends on cap_pkg (lane type and arctangent table).
module cap_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  cap_pkg::lane_t yin,
  input  cap_pkg::lane_t pin,
  input  cap_pkg::side_t sin,
  output cap_pkg::lane_t yout,
  output cap_pkg::lane_t pout,
  output cap_pkg::side_t sout
);
  import cap_pkg::*;

  localparam logic signed [CW-1:0] ATAN = $signed({2'b00, ATAN_Q30[IDX]});

  function automatic lane_t step(lane_t l);
    lane_t o;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = $signed(l.x) >>> IDX;
    ys = $signed(l.y) >>> IDX;
    if (!l.y[CW-1]) begin
      o.x   = l.x + ys;
      o.y   = l.y - xs;
      o.acc = l.acc + ATAN;
    end else begin
      o.x   = l.x - ys;
      o.y   = l.y + xs;
      o.acc = l.acc - ATAN;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    yout <= step(yin);
    pout <= step(pin);
    if (rst) begin
      sout <= '0;
    end else begin
      sout <= sin;
    end
  end

endmodule

// ----- sim/tb_camera_aim_pan_tilt_unit.sv -----
// Testbench for camera_aim_pan_tilt_unit: pose loads, aim beats, yaw continuity.
// Depends on cap_pkg and the RTL top; self-checking against a bit-exact predictor.
module tb_camera_aim_pan_tilt_unit;
  import cap_pkg::*;

  localparam int AFB      = ANGLE_FRAC_BITS_DEF;
  localparam int STAGES   = CORDIC_STAGES_DEF;
  localparam int LATENCY  = 51 + STAGES;
  localparam int WATCHDOG = 20000;
  localparam int N_RAND   = 1400;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_beat_t  item;
  logic      done;
  out_beat_t res;

  camera_aim_pan_tilt_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .res(res)
  );

  // Predictor state: pose as the block should hold it.
  longint rot_m[9];
  longint cam_pos[3];
  out_beat_t aim_q[$];

  int errors;
  int mismatches;
  int aims_checked;
  int beats_sent;
  int idle_cycles;
  int send_idle_pct;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_angle(longint q30);
    return (q30 + (longint'(1) <<< (29 - AFB))) >>> (30 - AFB);
  endfunction

  function automatic longint pi_fix();
    return round_angle(Q30_PI);
  endfunction

  function automatic longint clamp_pi(longint a);
    if (a > pi_fix()) return pi_fix();
    if (a < -pi_fix()) return -pi_fix();
    return a;
  endfunction

  function automatic longint wrap_pi(longint a);
    longint p;
    longint t;
    p = pi_fix();
    if (a <= p && a >= -p) return a;
    t = (a + p) % (2 * p);
    if (t < 0) t += 2 * p;
    return t - p;
  endfunction

  // Vectoring CORDIC, Q2.30 accumulator; >>> is floor shift on longint.
  function automatic longint atan2_q30(longint y, longint x);
    longint acc;
    longint nx;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? Q30_PI : -Q30_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        acc += longint'(ATAN_Q30[i]);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        acc -= longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    return acc;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Applies one beat to the predicted pose; queues the expected aim result.
  task automatic predict_aim(input in_beat_t b);
    longint v[3];
    longint dlt[3];
    longint cam[3];
    longint sc[3];
    longint unsigned mg[3];
    longint unsigned mx, a0, a1, a2;
    longint y1, y2, p1, pv, n1, n2, d1, d2;
    int nb;
    out_beat_t e;
    v[0] = b.vec_x;
    v[1] = b.vec_y;
    v[2] = b.vec_z;
    if (b.kind <= KIND_ROW2) begin
      for (int i = 0; i < 3; i++)
        rot_m[b.kind * 3 + i] = (v[i] > 131071) ? 131071 :
                                 (v[i] < -131072) ? -131072 : v[i];
      return;
    end
    if (b.kind == KIND_POS) begin
      for (int i = 0; i < 3; i++) cam_pos[i] = v[i];
      return;
    end
    if (b.kind != KIND_AIM) return;
    e = '0;
    for (int i = 0; i < 3; i++) dlt[i] = v[i] - cam_pos[i];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      cam[i] = 0;
      for (int j = 0; j < 3; j++) cam[i] += rot_m[j * 3 + i] * dlt[j];
      mg[i] = (cam[i] < 0) ? longint'(-cam[i]) : cam[i];
      if (mg[i] > mx) mx = mg[i];
    end
    if (mx == 0) begin
      e.pitch = 16'(clamp_pi(round_angle(Q30_HALF_PI)));
      aim_q.push_back(e);
      return;
    end
    nb = 0;
    while (nb < 64 && (mx >> nb) != 0) nb++;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (nb > 30) ? (mg[i] >> (nb - 30)) : (mg[i] << (30 - nb));
      sc[i] = (cam[i] < 0) ? -longint'(mg[i]) : longint'(mg[i]);
    end
    a0 = mg[0] >> 9;
    a1 = mg[1] >> 9;
    a2 = mg[2] >> 9;
    if ((a0 * a0 + a1 * a1) * 64'd499999 < a2 * a2) begin
      e.near_vertical = 1'b1;
      e.yaw = b.first_update ? 16'sd0 : b.last_yaw;
      aim_q.push_back(e);
      return;
    end
    y1 = clamp_pi(round_angle(atan2_q30(sc[1], sc[0])));
    p1 = clamp_pi(round_angle(atan2_q30(
           longint'(floor_sqrt(mg[0] * mg[0] + mg[1] * mg[1])), sc[2])));
    if (b.first_update) begin
      e.pitch = 16'(p1);
      e.yaw = 16'(y1);
    end else begin
      // Inverted solution: yaw turned by pi, pitch negated; base wins a tie.
      y2 = (y1 >= 0) ? y1 - pi_fix() : y1 + pi_fix();
      pv = wrap_pi(longint'(b.last_yaw));
      n1 = wrap_pi(y1);
      n2 = wrap_pi(y2);
      d1 = wrap_pi(n1 - pv);
      d2 = wrap_pi(n2 - pv);
      if (d1 < 0) d1 = -d1;
      if (d2 < 0) d2 = -d2;
      e.pitch = 16'((d1 <= d2) ? p1 : -p1);
      e.yaw = 16'((d1 <= d2) ? n1 : n2);
    end
    aim_q.push_back(e);
  endtask

  // Result monitor: done marks a single-cycle beat, compare against oldest.
  always @(posedge clk) begin
    out_beat_t w;
    if (!rst && done) begin
      if (aim_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("ERROR: unexpected result %p", res);
      end else begin
        w = aim_q.pop_front();
        aims_checked++;
        if (res.pitch !== w.pitch || res.yaw !== w.yaw ||
            res.near_vertical !== w.near_vertical) begin
          errors++;
          if (mismatches++ < 10)
            $display("ERROR: pitch/yaw/nv exp %0d/%0d/%0d got %0d/%0d/%0d",
                     w.pitch, w.yaw, w.near_vertical,
                     res.pitch, res.yaw, res.near_vertical);
        end
      end
    end
  end

  // Watchdog: counts cycles where neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Holds start for one accepted beat, with random sender gaps before it.
  task automatic send_beat(input in_beat_t b, input int gap_pct);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= b;
    do @(posedge clk); while (busy);
    predict_aim(b);
    beats_sent++;
  endtask

  function automatic logic signed [31:0] rand_q16(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed(32'($urandom_range(2000000, 0)) - 32'sd1000000);
      default: return $signed(32'($urandom_range(200, 0)) - 32'sd100) <<< 16;
    endcase
  endfunction

  // Random row: mostly near-unit rotation-like entries, some full range.
  function automatic in_beat_t rand_beat(int k);
    in_beat_t b;
    int md;
    b.kind = 3'(k);
    md = $urandom_range(2, 0);
    b.vec_x = rand_q16(md);
    b.vec_y = rand_q16(md);
    b.vec_z = rand_q16(md);
    if (k <= KIND_ROW2 && $urandom_range(3, 0) != 0) begin
      b.vec_x = $signed(32'($urandom_range(131072, 0)) - 32'sd65536);
      b.vec_y = $signed(32'($urandom_range(131072, 0)) - 32'sd65536);
      b.vec_z = $signed(32'($urandom_range(131072, 0)) - 32'sd65536);
    end
    b.last_yaw = $signed(16'($urandom));
    if ($urandom_range(1, 0)) b.last_yaw = $signed(16'($urandom_range(51472, 0)) - 16'sd25736);
    b.first_update = $urandom_range(3, 0) == 0;
    return b;
  endfunction

  // Directed rows. Expected value typed in where obvious; known 0 = predictor only.
  typedef struct {
    in_beat_t  b;
    int        known;
    out_beat_t r;
  } row_t;

  row_t dir_rows[$];

  function automatic row_t mk(logic [2:0] k, logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic signed [15:0] py, logic f,
                              int known, logic signed [15:0] ep, logic signed [15:0] ey,
                              logic env);
    row_t t;
    t.b = '{k, x, y, z, py, f};
    t.known = known;
    t.r = '{ep, ey, env};
    return t;
  endfunction

  initial begin
    in_beat_t b;
    out_beat_t w;
    int k;
    int mode_cnt;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    errors = 0;
    mismatches = 0;
    aims_checked = 0;
    beats_sent = 0;
    timed_out = 1'b0;
    send_idle_pct = 0;
    for (int i = 0; i < 9; i++) rot_m[i] = (i % 4 == 0) ? 65536 : 0;
    for (int i = 0; i < 3; i++) cam_pos[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Watchdog process
    fork
      begin
        wait (idle_cycles >= WATCHDOG);
        $display("ERROR: watchdog expired");
        $display("Simulation FAILED");
        $finish;
      end
    join_none

    // Identity pose after reset: zero offset, straight up and down, +x, -x, -y,
    // then unused kinds, extreme positions and saturating rows.
    dir_rows.push_back(mk(KIND_AIM, 0, 0, 0, 0, 1, 1, 16'sd12868, 0, 0));
    dir_rows.push_back(mk(KIND_AIM, 0, 0, 32'sd65536, 16'sd1234, 0, 1, 0, 16'sd1234, 1));
    dir_rows.push_back(mk(KIND_AIM, 0, 0, 32'sd65536, 16'sd1234, 1, 1, 0, 0, 1));
    dir_rows.push_back(mk(KIND_AIM, 0, 0, -32'sd65536, -16'sd32768, 0, 1, 0, -16'sd32768, 1));
    dir_rows.push_back(mk(KIND_AIM, 32'sd65536, 0, 0, 0, 1, 1, 16'sd12868, 0, 0));
    dir_rows.push_back(mk(KIND_AIM, -32'sd65536, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_AIM, -32'sd65536, 0, 0, 16'sd25000, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_AIM, 0, -32'sd65536, 32'sd100, 16'sd32767, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_AIM, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, 1,
                          0, 0, 0, 0));
    dir_rows.push_back(mk(3'd5, 1, 2, 3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(3'd6, 1, 2, 3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(3'd7, 1, 2, 3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_POS, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0,
                          0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_AIM, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                          16'sh5555, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_ROW0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_ROW1, 32'sh80000000, 32'sd131071, -32'sd131072, 0, 0,
                          0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_ROW2, 32'sd131072, -32'sd131073, 32'sh7FFFFFFF, 0, 0,
                          0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_AIM, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                          -16'sd25736, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_POS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_AIM, 32'sd65536, 32'sd65536, 32'sd65536, 16'sd25736, 1,
                          0, 0, 0, 0));

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].b, 0);
      if (dir_rows[i].known == 1) begin
        w = aim_q[$];
        if (w !== dir_rows[i].r) begin
          errors++;
          if (mismatches++ < 10)
            $display("ERROR: directed row %0d predictor %p table %p", i, w, dir_rows[i].r);
        end
      end
    end

    // Random beats in idle phases: none, 75%, 17%, none. Mostly aim beats with
    // occasional pose reloads so several poses and continuity paths are seen.
    for (int n = 0; n < N_RAND; n++) begin
      mode_cnt = n / (N_RAND / 4);
      send_idle_pct = (mode_cnt == 1) ? 75 : (mode_cnt == 2) ? 17 : 0;
      if ($urandom_range(19, 0) == 0) send_idle_pct = 0;
      k = $urandom_range(99, 0);
      if (k < 8) k = $urandom_range(2, 0);
      else if (k < 12) k = KIND_POS;
      else if (k < 14) k = $urandom_range(7, 5);
      else k = KIND_AIM;
      b = rand_beat(k);
      send_beat(b, send_idle_pct);
    end
    start <= 1'b0;

    // Drain, then allow a pipeline's worth of cycles for stray results.
    while (aim_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d beats; %0d aim results checked, %0d mismatches.",
             beats_sent, aims_checked, errors);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
